// File: rtl/core/cpbc_pkg.sv
// Shared constants, codes and types for the ball closing block.
package cpbc_pkg;

    localparam int MAX_POINTS_DEF      = 2048;
    localparam int MAX_HALF_WINDOW_DEF = 256;
    localparam int SAMPLE_WIDTH_DEF    = 24;

    localparam int CFG_W = 16;
    localparam int RAD_W = 2 * CFG_W;

    localparam logic [CFG_W-1:0] BALL_RADIUS_RST = 16'd512;
    localparam logic [CFG_W-1:0] STEP_LEN_RST    = 16'd102;

    localparam int MIN_POINTS = 5;

    typedef enum logic {
        CFG_BALL_RADIUS = 1'b0,
        CFG_STEP_LEN    = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        EXT_MAX = 1'b0,
        EXT_MIN = 1'b1
    } ext_op_t;

    typedef struct packed {
        logic    en;
        logic    first;
        ext_op_t op;
    } ext_ctrl_t;

endpackage

// File: rtl/core/circular_profile_ball_closing.sv
// Top level: profile store, dome table, sequencer and result register.
//
// A load request (tuser = 0) stores one sample while the store has room. The load
// marked tlast closes the profile and, unless the profile is bypassed, the block
// then stays busy: it finds the half window k = ceil(R/step), at most MAX_HALF_WINDOW,
// computes the k+1 dome entries (one shared multiplier and a 16-step square root for
// each offset inside the radius, zero for each one outside it), finds the wrapped
// window start and runs the dilation pass. A fetch request (tuser = 1) runs the
// erosion pass, or only reads the sample when the profile is bypassed, and then waits
// while the previous result still sits in the output register. Both window passes are
// bound by the single read port of the sample and dilation memories: one neighbor per
// cycle. A fetch before any profile is closed is taken and gives no result.
module circular_profile_ball_closing
    import cpbc_pkg::*;
#(
    parameter int MAX_POINTS      = MAX_POINTS_DEF,
    parameter int MAX_HALF_WINDOW = MAX_HALF_WINDOW_DEF,
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // sample
    input  logic                                  s_axis_tuser,  // mode
    input  logic                                  s_axis_tlast,  // last
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,  // smoothed
    output logic [1:0]                            m_axis_tuser,  // window_clipped, bypassed
    output logic                                  m_axis_tlast,  // last_out
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_index,
    input  logic [CFG_W-1:0]                      cfg_data
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int HW  = $clog2(MAX_HALF_WINDOW + 1);
    localparam int WCW = $clog2(2 * MAX_HALF_WINDOW + 1);
    localparam int DW  = (SAMPLE_WIDTH > CFG_W) ? SAMPLE_WIDTH + 1 : CFG_W + 2;
    localparam int ACW = CFG_W + 1;
    localparam int SW  = ((NW > HW) ? NW : HW) + 1;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_KSRCH  = 13'b0000000000010,
        ST_DMUL   = 13'b0000000000100,
        ST_DSQ    = 13'b0000000001000,
        ST_DWAIT  = 13'b0000000010000,
        ST_WRAP   = 13'b0000000100000,
        ST_DIL    = 13'b0000001000000,
        ST_DDRAIN = 13'b0000010000000,
        ST_DWR    = 13'b0000100000000,
        ST_ERO    = 13'b0001000000000,
        ST_EDRAIN = 13'b0010000000000,
        ST_BRD    = 13'b0100000000000,
        ST_FIN    = 13'b1000000000000
    } state_t;

    // memories
    logic [W-1:0]     sample_mem [MAX_POINTS];
    logic [DW-1:0]    dilated_mem [MAX_POINTS];
    logic [CFG_W-1:0] dome_mem [MAX_HALF_WINDOW + 1];

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  radius_reg, step_reg;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     wstart_reg, wstart_next;
    logic [AW-1:0]     start0_reg, start0_next;
    logic [AW-1:0]     j_reg, j_next;
    logic [WCW-1:0]    wcnt_reg, wcnt_next;
    logic [HW-1:0]     k_reg, k_next;
    logic [HW-1:0]     t_reg, t_next;
    logic [ACW-1:0]    acc_reg, acc_next;
    logic signed [SW-1:0] sacc_reg, sacc_next;
    logic              computed_reg, computed_next;
    logic              bypass_reg, bypass_next;
    logic              clip_reg, clip_next;
    logic              pv_reg, pv_next;
    logic              pfirst_reg, pfirst_next;
    logic [RAD_W-1:0]  r2_reg, d2_reg;
    logic [RAD_W-1:0]  mul_res;
    logic [CFG_W-1:0]  mul_op;

    logic              mo_valid_reg, mo_valid_next;
    logic [W-1:0]      mo_data_reg;
    logic              mo_last_reg, mo_clip_reg, mo_byp_reg;
    logic              mo_load;

    logic              in_acc;
    logic [NW-1:0]     cnt_eff, cnt_new;
    logic              samp_we;
    logic [AW-1:0]     samp_waddr, samp_raddr;
    logic [W-1:0]      samp_rd;
    logic              dil_we;
    logic [DW-1:0]     dil_rd;
    logic              dome_we;
    logic [CFG_W-1:0]  dome_wdata, dome_rd;
    logic [HW-1:0]     dome_addr;
    logic [WCW-1:0]    k_w;
    logic [HW-1:0]     a_off;
    logic [NW-1:0]     m_val;
    logic [AW-1:0]     j_inc, ws_inc;
    logic              idx_last;
    logic              win_end;
    logic              dt_below;
    logic              sq_start, sq_done;
    logic [CFG_W-1:0]  sq_root;
    ext_ctrl_t         ext_ctrl;
    logic signed [DW-1:0] ext_base, ext_best, samp_ext;
    logic [W-1:0]      res_val;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= BALL_RADIUS_RST;
            step_reg   <= STEP_LEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BALL_RADIUS: radius_reg <= cfg_data;
                CFG_STEP_LEN:    step_reg   <= cfg_data;
                default:         radius_reg <= radius_reg;
            endcase
        end
    end

    // window index helpers
    always_comb
    begin
        m_val    = cnt_reg - 1'b1;
        j_inc    = (NW'(j_reg) == m_val - 1'b1) ? '0 : j_reg + 1'b1;
        ws_inc   = (NW'(wstart_reg) == m_val - 1'b1) ? '0 : wstart_reg + 1'b1;
        idx_last = (NW'(idx_reg) == m_val);
        k_w      = WCW'(k_reg);
        a_off    = (wcnt_reg >= k_w) ? HW'(wcnt_reg - k_w) : HW'(k_w - wcnt_reg);
        win_end  = (wcnt_reg == {k_w[WCW-2:0], 1'b0});
        dt_below = (acc_reg < {1'b0, radius_reg});
        mul_op   = (state_reg == ST_DMUL) ? acc_reg[CFG_W-1:0] : radius_reg;
        mul_res  = RAD_W'(mul_op) * RAD_W'(mul_op);
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        wstart_next   = wstart_reg;
        start0_next   = start0_reg;
        j_next        = j_reg;
        wcnt_next     = wcnt_reg;
        k_next        = k_reg;
        t_next        = t_reg;
        acc_next      = acc_reg;
        sacc_next     = sacc_reg;
        computed_next = computed_reg;
        bypass_next   = bypass_reg;
        clip_next     = clip_reg;
        pv_next       = 1'b0;
        pfirst_next   = 1'b0;
        cnt_eff       = computed_reg ? '0 : cnt_reg;
        cnt_new       = cnt_eff;
        samp_we       = 1'b0;
        samp_waddr    = cnt_eff[AW-1:0];
        dil_we        = 1'b0;
        dome_we       = 1'b0;
        dome_wdata    = sq_root;
        sq_start      = 1'b0;
        mo_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !s_axis_tuser)
                begin
                    if (cnt_eff < NW'(MAX_POINTS))
                    begin
                        samp_we = 1'b1;
                        cnt_new = cnt_eff + 1'b1;
                    end
                    cnt_next      = cnt_new;
                    computed_next = 1'b0;
                    idx_next      = '0;
                    if (s_axis_tlast)
                    begin
                        computed_next = 1'b1;
                        clip_next     = 1'b0;
                        k_next        = '0;
                        bypass_next   = (radius_reg == '0) || (cnt_new < NW'(MIN_POINTS));
                        if (!((radius_reg == '0) || (cnt_new < NW'(MIN_POINTS))))
                        begin
                            t_next     = HW'(1);
                            acc_next   = {1'b0, step_reg};
                            state_next = ST_KSRCH;
                        end
                    end
                end
                else if (in_acc && computed_reg)
                begin
                    if (bypass_reg)
                    begin
                        state_next = ST_BRD;
                    end
                    else
                    begin
                        j_next     = wstart_reg;
                        wcnt_next  = '0;
                        state_next = ST_ERO;
                    end
                end
            end

            ST_KSRCH:
            begin
                if (step_reg == '0 || (!dt_below && t_reg == '0))
                begin
                    k_next    = HW'(MAX_HALF_WINDOW);
                    clip_next = 1'b1;
                end
                if (step_reg == '0)
                begin
                    t_next     = '0;
                    acc_next   = '0;
                    state_next = ST_DMUL;
                end
                else if (!dt_below)
                begin
                    k_next     = t_reg;
                    t_next     = '0;
                    acc_next   = '0;
                    state_next = ST_DMUL;
                end
                else if (t_reg == HW'(MAX_HALF_WINDOW))
                begin
                    k_next     = HW'(MAX_HALF_WINDOW);
                    clip_next  = 1'b1;
                    t_next     = '0;
                    acc_next   = '0;
                    state_next = ST_DMUL;
                end
                else
                begin
                    t_next   = t_reg + 1'b1;
                    acc_next = acc_reg + ACW'(step_reg);
                end
            end

            ST_DMUL:
            begin
                state_next = ST_DSQ;
            end

            ST_DSQ, ST_DWAIT:
            begin
                if (state_reg == ST_DSQ && dt_below)
                begin
                    sq_start   = 1'b1;
                    state_next = ST_DWAIT;
                end
                else if (state_reg == ST_DSQ || sq_done)
                begin
                    dome_we    = 1'b1;
                    dome_wdata = (state_reg == ST_DSQ) ? '0 : sq_root;
                    if (t_reg == k_reg)
                    begin
                        sacc_next  = -(SW'(k_reg));
                        state_next = ST_WRAP;
                    end
                    else
                    begin
                        t_next     = t_reg + 1'b1;
                        acc_next   = acc_reg + ACW'(step_reg);
                        state_next = ST_DMUL;
                    end
                end
            end

            ST_WRAP:
            begin
                // wrap the first window start (-k) into one period
                if (sacc_reg[SW-1])
                begin
                    sacc_next = sacc_reg + SW'(m_val);
                end
                else
                begin
                    start0_next = sacc_reg[AW-1:0];
                    wstart_next = sacc_reg[AW-1:0];
                    j_next      = sacc_reg[AW-1:0];
                    idx_next    = '0;
                    wcnt_next   = '0;
                    state_next  = ST_DIL;
                end
            end

            ST_DIL, ST_ERO:
            begin
                pv_next     = 1'b1;
                pfirst_next = (wcnt_reg == '0);
                wcnt_next   = wcnt_reg + 1'b1;
                j_next      = j_inc;
                if (win_end)
                begin
                    state_next = (state_reg == ST_DIL) ? ST_DDRAIN : ST_EDRAIN;
                end
            end

            ST_DDRAIN:
            begin
                state_next = ST_DWR;
            end

            ST_DWR:
            begin
                dil_we = 1'b1;
                if (idx_last)
                begin
                    idx_next    = '0;
                    wstart_next = start0_reg;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    idx_next    = idx_reg + 1'b1;
                    wstart_next = ws_inc;
                    j_next      = ws_inc;
                    wcnt_next   = '0;
                    state_next  = ST_DIL;
                end
            end

            ST_EDRAIN, ST_BRD:
            begin
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (!mo_valid_reg || m_axis_tready)
                begin
                    mo_load = 1'b1;
                    if (idx_last)
                    begin
                        idx_next    = '0;
                        wstart_next = start0_reg;
                    end
                    else
                    begin
                        idx_next    = idx_reg + 1'b1;
                        wstart_next = ws_inc;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            wstart_reg   <= '0;
            start0_reg   <= '0;
            j_reg        <= '0;
            wcnt_reg     <= '0;
            k_reg        <= '0;
            t_reg        <= '0;
            acc_reg      <= '0;
            sacc_reg     <= '0;
            computed_reg <= 1'b0;
            bypass_reg   <= 1'b0;
            clip_reg     <= 1'b0;
            pv_reg       <= 1'b0;
            pfirst_reg   <= 1'b0;
            mo_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            wstart_reg   <= wstart_next;
            start0_reg   <= start0_next;
            j_reg        <= j_next;
            wcnt_reg     <= wcnt_next;
            k_reg        <= k_next;
            t_reg        <= t_next;
            acc_reg      <= acc_next;
            sacc_reg     <= sacc_next;
            computed_reg <= computed_next;
            bypass_reg   <= bypass_next;
            clip_reg     <= clip_next;
            pv_reg       <= pv_next;
            pfirst_reg   <= pfirst_next;
            mo_valid_reg <= mo_valid_next;
        end
    end

    // shared multiplier: R*R during the window search, dt*dt per dome entry
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_KSRCH)
        begin
            r2_reg <= mul_res;
        end
        if (state_reg == ST_DMUL)
        begin
            d2_reg <= mul_res;
        end
    end

    // memories, read data registered
    assign samp_raddr = (state_reg == ST_DIL) ? j_reg : idx_reg;
    assign dome_addr  = (state_reg == ST_DSQ || state_reg == ST_DWAIT) ? t_reg : a_off;

    always_ff @(posedge clk)
    begin
        if (samp_we)
        begin
            sample_mem[samp_waddr] <= s_axis_tdata[W-1:0];
        end
        samp_rd <= sample_mem[samp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dil_we)
        begin
            dilated_mem[idx_reg] <= ext_best;
        end
        dil_rd <= dilated_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (dome_we)
        begin
            dome_mem[dome_addr] <= dome_wdata;
        end
        dome_rd <= dome_mem[dome_addr];
    end

    cpbc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (r2_reg - d2_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign samp_ext    = $signed({{(DW-W){samp_rd[W-1]}}, samp_rd});
    assign ext_ctrl.en    = pv_reg;
    assign ext_ctrl.first = pfirst_reg;
    assign ext_ctrl.op    = (state_reg == ST_DIL || state_reg == ST_DDRAIN) ? EXT_MAX : EXT_MIN;
    assign ext_base = (ext_ctrl.op == EXT_MAX) ? samp_ext : $signed(dil_rd);

    cpbc_extreme #(
        .DW (DW)
    ) u_extreme (
        .clk  (clk),
        .ctrl (ext_ctrl),
        .base (ext_base),
        .dome (dome_rd),
        .best (ext_best)
    );

    // clamp to at least the original sample
    assign res_val = (bypass_reg || !(ext_best > samp_ext)) ? samp_rd : ext_best[W-1:0];

    always_comb
    begin
        mo_valid_next = mo_valid_reg;
        if (m_axis_tvalid && m_axis_tready)
        begin
            mo_valid_next = 1'b0;
        end
        if (mo_load)
        begin
            mo_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mo_load)
        begin
            mo_data_reg <= res_val;
            mo_last_reg <= idx_last;
            mo_clip_reg <= clip_reg && !bypass_reg;
            mo_byp_reg  <= bypass_reg;
        end
    end

    assign m_axis_tvalid = mo_valid_reg;
    assign m_axis_tdata  = TDW'(mo_data_reg);
    assign m_axis_tlast  = mo_last_reg;
    assign m_axis_tuser  = {mo_byp_reg, mo_clip_reg};

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= NW'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside the final fetch step");

    a_win_in_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIL || state_reg == ST_ERO) |-> (NW'(j_reg) < cnt_reg - 1'b1))
        else $error("window index outside the profile period");

    a_clip_not_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        clip_reg |-> !bypass_reg)
        else $error("clipped window on a bypassed profile");

endmodule

// File: rtl/core/cpbc_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module cpbc_isqrt
    import cpbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RAD_W-1:0] radicand,
    output logic             done,
    output logic [CFG_W-1:0] root
);

    localparam int ITERS = RAD_W / 2;
    localparam int CW    = $clog2(ITERS + 1);

    logic [RAD_W-1:0] x_reg, x_next;
    logic [CFG_W+1:0] rem_reg, rem_next;
    logic [CFG_W-1:0] root_reg, root_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CFG_W+1:0] rem_sh;
    logic [CFG_W+1:0] trial;

    always_comb
    begin
        rem_sh    = {rem_reg[CFG_W-1:0], x_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(ITERS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[CFG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[CFG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/core/cpbc_extreme.sv
// Shared add/subtract and running max/min accumulator for both window passes.
module cpbc_extreme
    import cpbc_pkg::*;
#(
    parameter int DW = SAMPLE_WIDTH_DEF + 1
)
(
    input  logic                 clk,
    input  ext_ctrl_t            ctrl,
    input  logic signed [DW-1:0] base,
    input  logic [CFG_W-1:0]     dome,
    output logic signed [DW-1:0] best
);

    logic signed [DW-1:0] dome_s;
    logic signed [DW-1:0] v;
    logic signed [DW-1:0] best_reg, best_next;
    logic                 better;

    always_comb
    begin
        dome_s = $signed({{(DW-CFG_W){1'b0}}, dome});
        if (ctrl.op == EXT_MAX)
        begin
            v      = base + dome_s;
            better = (v > best_reg);
        end
        else
        begin
            v      = base - dome_s;
            better = (v < best_reg);
        end
        best_next = best_reg;
        if (ctrl.en && (ctrl.first || better))
        begin
            best_next = v;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    assign best = best_reg;

endmodule

// File: bench/circular_profile_ball_closing_test.sv
// Self-checking testbench for the ball closing block: directed and random profiles.
`timescale 1ns / 100ps

module circular_profile_ball_closing_test;
    import cpbc_pkg::*;

    localparam int NPTS  = MAX_POINTS_DEF;
    localparam int HWMAX = MAX_HALF_WINDOW_DEF;
    localparam int SW    = SAMPLE_WIDTH_DEF;
    localparam int DW    = ((SW + 7) / 8) * 8;

    typedef struct {
        logic [SW-1:0] smoothed;
        logic          last_out;
        logic          clipped;
        logic          bypassed;
    } closed_point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;   // sample
    logic s_axis_tuser = 1'b0;          // mode
    logic s_axis_tlast = 1'b0;          // last
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;        // smoothed
    logic [1:0] m_axis_tuser;           // window_clipped, bypassed
    logic m_axis_tlast;                 // last_out
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;

    circular_profile_ball_closing dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow state of the block
    int unsigned radius_reg = 512;
    int unsigned step_reg = 102;
    longint profile_pts [NPTS];
    longint dilated_pts [NPTS];
    longint unsigned dome_h [HWMAX+1];
    int unsigned n_pts = 0;
    int unsigned next_fetch = 0;
    bit closed = 0;
    int half_w = 0;
    bit clip_f = 0;
    bit bypass_f = 0;
    int unsigned settle_cycles = 16;

    closed_point_t closing_q [$];
    int errors = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold = 0;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int wrap_pos(int v, int period);
        int j;
        j = v % period;
        if (j < 0)
            j += period;
        return j;
    endfunction

    task automatic close_profile();
        longint unsigned kk;
        longint unsigned r2;
        longint unsigned d2;
        longint best;
        longint v;
        int m;
        clip_f = 0;
        half_w = 0;
        bypass_f = (radius_reg == 0) || (n_pts < MIN_POINTS);
        settle_cycles = 32;
        if (bypass_f)
            return;
        if (step_reg == 0)
            kk = HWMAX + 1;
        else
            kk = (longint'(radius_reg) + step_reg - 1) / step_reg;
        if (kk < 1)
            kk = 1;
        if (kk > HWMAX)
        begin
            kk = HWMAX;
            clip_f = 1;
        end
        half_w = int'(kk);
        r2 = longint'(radius_reg) * radius_reg;
        for (int t = 0; t <= half_w; t++)
        begin
            d2 = (longint'(t) * step_reg) * (longint'(t) * step_reg);
            dome_h[t] = (d2 < r2) ? int_sqrt(r2 - d2) : 0;
        end
        m = n_pts - 1;
        for (int i = 0; i < n_pts; i++)
        begin
            best = 0;
            for (int off = -half_w; off <= half_w; off++)
            begin
                v = profile_pts[wrap_pos(i + off, m)] + longint'(dome_h[off < 0 ? -off : off]);
                if (off == -half_w || v > best)
                    best = v;
            end
            dilated_pts[i] = best;
        end
        settle_cycles = 20 * (half_w + 2) + half_w + n_pts * (2 * half_w + 3) + 64;
    endtask

    task automatic predict_closing(bit mode, logic [SW-1:0] smp, bit is_last);
        closed_point_t r;
        longint lo;
        longint v;
        int i;
        int m;
        if (mode == 1'b0)
        begin
            if (closed)
            begin
                n_pts = 0;
                next_fetch = 0;
                closed = 0;
            end
            if (n_pts < NPTS)
            begin
                profile_pts[n_pts] = longint'($signed(smp));
                n_pts++;
            end
            if (is_last)
            begin
                close_profile();
                next_fetch = 0;
                closed = 1;
            end
            return;
        end
        if (!closed)
            return;
        i = (next_fetch >= n_pts) ? 0 : next_fetch;
        if (bypass_f)
            lo = profile_pts[i];
        else
        begin
            m = n_pts - 1;
            lo = 0;
            for (int off = -half_w; off <= half_w; off++)
            begin
                v = dilated_pts[wrap_pos(i + off, m)] - longint'(dome_h[off < 0 ? -off : off]);
                if (off == -half_w || v < lo)
                    lo = v;
            end
            if (profile_pts[i] > lo)
                lo = profile_pts[i];
        end
        r.smoothed = lo[SW-1:0];
        r.last_out = (i + 1 == n_pts);
        r.clipped = !bypass_f && clip_f;
        r.bypassed = bypass_f;
        closing_q.push_back(r);
        next_fetch = (i + 1 >= n_pts) ? 0 : i + 1;
    endtask

    // Result checker and receiver-side backpressure
    always @(posedge clk)
    begin
        closed_point_t e;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (closing_q.size() == 0)
            begin
                $error("unexpected result smoothed=%0h", m_axis_tdata[SW-1:0]);
                errors++;
            end
            else
            begin
                e = closing_q.pop_front();
                if (m_axis_tdata[SW-1:0] !== e.smoothed)
                begin
                    $error("smoothed: expected %0h, got %0h", e.smoothed, m_axis_tdata[SW-1:0]);
                    errors++;
                end
                if (m_axis_tlast !== e.last_out)
                begin
                    $error("last_out: expected %0b, got %0b", e.last_out, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser[0] !== e.clipped)
                begin
                    $error("window_clipped: expected %0b, got %0b", e.clipped, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[1] !== e.bypassed)
                begin
                    $error("bypassed: expected %0b, got %0b", e.bypassed, m_axis_tuser[1]);
                    errors++;
                end
            end
        end
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic send_item(bit mode, logic [SW-1:0] smp, bit is_last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= DW'(smp);
        s_axis_tlast <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_closing(mode, smp, is_last);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (closing_q.size() != 0)
            @(posedge clk);
        repeat (settle_cycles) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_BALL_RADIUS)
            radius_reg = val;
        else
            step_reg = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(int unsigned r, int unsigned st);
        wait_drained();
        write_reg(CFG_BALL_RADIUS, r[CFG_W-1:0]);
        write_reg(CFG_STEP_LEN, st[CFG_W-1:0]);
    endtask

    // Load a closed profile: the final sample usually repeats the first
    task automatic load_profile(int n, bit full_range);
        logic [SW-1:0] first;
        logic [SW-1:0] s;
        int lvl;
        lvl = $urandom_range(4000) - 2000;
        first = '0;
        for (int i = 0; i < n; i++)
        begin
            if (full_range)
                s = SW'($urandom);
            else
            begin
                lvl += int'($urandom_range(600)) - 300;
                s = SW'(lvl);
            end
            if (i == 0)
                first = s;
            if (i == n - 1 && $urandom_range(7) != 0)
                s = first;
            send_item(1'b0, s, i == n - 1);
        end
    endtask

    task automatic fetch_points(int cnt);
        for (int i = 0; i < cnt; i++)
            send_item(1'b1, SW'($urandom), $urandom_range(1));
    endtask

    task automatic test_fetch_before_load();
        fetch_points(3);
    endtask

    task automatic test_directed_profiles();
        logic [SW-1:0] pts [8];
        pts = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                24'h000100, 24'h7FFF00, 24'h800100, 24'h7FFFFF};
        for (int i = 0; i < 8; i++)
            send_item(1'b0, pts[i], i == 7);
        fetch_points(10);
        // fewer than five samples pass through
        send_item(1'b0, 24'h001234, 1'b0);
        send_item(1'b0, 24'h800000, 1'b0);
        send_item(1'b0, 24'h001234, 1'b1);
        fetch_points(4);
    endtask

    task automatic test_config_extremes();
        int unsigned geo [5][2];
        geo = '{'{0, 102}, '{65535, 1}, '{512, 0}, '{65535, 65535}, '{1, 65535}};
        for (int g = 0; g < 5; g++)
        begin
            set_geometry(geo[g][0], geo[g][1]);
            load_profile(6, g[0]);
            fetch_points(7);
        end
    endtask

    task automatic test_backpressure();
        set_geometry(300, 100);
        load_profile(10, 1'b0);
        rx_hold = 400;
        fetch_points(20);
        wait_drained();
    endtask

    task automatic test_random_profiles(int tx_pct, int rx_pct, int n_items);
        int sent;
        int n;
        int r;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 4)
                set_geometry($urandom_range(65535), $urandom_range(65535));
            else if (r < 8)
                set_geometry(20000 + $urandom_range(45535), $urandom_range(1, 200));
            else if (r < 12)
                set_geometry(0, $urandom_range(1, 65535));
            else if (r < 35)
                set_geometry($urandom_range(1, 3000), $urandom_range(40, 1500));
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 24);
            load_profile(n, $urandom_range(3) == 0);
            sent += n;
            // broken sequence: a stray fetch in the middle of a reload
            if ($urandom_range(9) == 0)
            begin
                send_item(1'b0, SW'($urandom), 1'b0);
                fetch_points(1);
                send_item(1'b0, SW'($urandom), 1'b1);
                sent += 3;
            end
            n = n + $urandom_range(4);
            fetch_points(n);
            sent += n;
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fetch_before_load();
        test_directed_profiles();
        test_config_extremes();
        test_backpressure();
        test_random_profiles(0, 0, 250);
        test_random_profiles(88, 0, 250);
        test_random_profiles(0, 88, 250);
        test_random_profiles(27, 27, 250);
        wait_drained();
        repeat (600) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #80ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/cpbc_pkg.sv
rtl/core/cpbc_isqrt.sv
rtl/core/cpbc_extreme.sv
rtl/core/circular_profile_ball_closing.sv
bench/circular_profile_ball_closing_test.sv
